>>> rtl/clnw_pkg.sv
package clnw_pkg;

    // operation codes carried in the mode field
    typedef enum logic [3:0] {
        MODE_CMD         = 4'd0,
        MODE_DATA        = 4'd1,
        MODE_CHAR        = 4'd2,
        MODE_CURSOR_POS  = 4'd3,
        MODE_DISPLAY     = 4'd4,
        MODE_CURSOR_SHOW = 4'd5,
        MODE_BLINK       = 4'd6,
        MODE_CLEAR       = 4'd7,
        MODE_HOME        = 4'd8,
        MODE_GLYPH_SLOT  = 4'd9,
        MODE_GLYPH_PRINT = 4'd10
    } mode_t;

    localparam int unsigned FLAGS_W = 3;

    localparam logic [FLAGS_W-1:0] FLAG_DISPLAY = 3'b100;
    localparam logic [FLAGS_W-1:0] FLAG_CURSOR  = 3'b010;
    localparam logic [FLAGS_W-1:0] FLAG_BLINK   = 3'b001;
    localparam logic [FLAGS_W-1:0] FLAGS_RESET  = 3'b100;

    localparam logic [7:0] CMD_SET_DDRAM   = 8'h80;
    localparam logic [7:0] CMD_SET_CGRAM   = 8'h40;
    localparam logic [7:0] CMD_DISPLAY_CTL = 8'h08;
    localparam logic [7:0] CMD_CLEAR       = 8'h01;
    localparam logic [7:0] CMD_HOME        = 8'h02;

    localparam logic [7:0] ROW_OFFSET [4] = '{8'h00, 8'h40, 8'h14, 8'h54};

    localparam logic [7:0] CP_YO_CAP     = 8'hA8;
    localparam logic [7:0] CP_YO_SMALL   = 8'hB8;
    localparam logic [7:0] LCD_YO_CAP    = 8'hA2;
    localparam logic [7:0] LCD_YO_SMALL  = 8'hB5;

    // controller codes for cp1251 letters 0xc0..0xff
    localparam logic [7:0] CYR_TABLE [64] = '{
        8'h41, 8'hA0, 8'h42, 8'hA1, 8'hE0, 8'h45, 8'hA3, 8'hA4,
        8'hA5, 8'hA6, 8'h4B, 8'hA7, 8'h4D, 8'h48, 8'h4F, 8'hA8,
        8'h50, 8'h43, 8'h54, 8'hA9, 8'hAA, 8'h58, 8'hE1, 8'hAB,
        8'hAC, 8'hE2, 8'hAD, 8'hAE, 8'h62, 8'hAF, 8'hB0, 8'hB1,
        8'h61, 8'hB2, 8'hB3, 8'hB4, 8'hE3, 8'h65, 8'hB6, 8'hB7,
        8'hB8, 8'hB9, 8'hBA, 8'hBB, 8'hBC, 8'hBD, 8'h6F, 8'hBE,
        8'h70, 8'h63, 8'hBF, 8'h79, 8'hE4, 8'h78, 8'hE5, 8'hC0,
        8'hC1, 8'hE6, 8'hC2, 8'hC3, 8'hC4, 8'hC5, 8'hC6, 8'hC7
    };

    // result of encoding one item
    typedef struct packed {
        logic               send;
        logic               rs;
        logic [7:0]         data_byte;
        logic [FLAGS_W-1:0] flags;
    } enc_t;

endpackage

>>> rtl/clnw_encode.sv
module clnw_encode
    import clnw_pkg::*;
(
    input  logic [3:0]         mode,
    input  logic [7:0]         value,
    input  logic [1:0]         row,
    input  logic [FLAGS_W-1:0] flags,
    output enc_t               enc
);

    logic [7:0]         char_code;
    logic [FLAGS_W-1:0] flag_bit;
    logic [FLAGS_W-1:0] flags_upd;

    // cp1251 cyrillic to controller code page
    always_comb
    begin
        if (value[7:6] == 2'b11)
            char_code = CYR_TABLE[value[5:0]];
        else if (value == CP_YO_CAP)
            char_code = LCD_YO_CAP;
        else if (value == CP_YO_SMALL)
            char_code = LCD_YO_SMALL;
        else
            char_code = value;
    end

    always_comb
    begin
        case (mode)
            MODE_DISPLAY:     flag_bit = FLAG_DISPLAY;
            MODE_CURSOR_SHOW: flag_bit = FLAG_CURSOR;
            MODE_BLINK:       flag_bit = FLAG_BLINK;
            default:          flag_bit = '0;
        endcase
        flags_upd = (value != 8'd0) ? (flags | flag_bit) : (flags & ~flag_bit);
    end

    always_comb
    begin
        enc.send      = 1'b1;
        enc.rs        = 1'b0;
        enc.data_byte = value;
        enc.flags     = flags;
        case (mode)
            MODE_CMD:
            begin
                enc.data_byte = value;
            end
            MODE_DATA, MODE_GLYPH_PRINT:
            begin
                enc.rs        = 1'b1;
                enc.data_byte = value;
            end
            MODE_CHAR:
            begin
                enc.rs        = 1'b1;
                enc.data_byte = char_code;
            end
            MODE_CURSOR_POS:
            begin
                enc.data_byte = (ROW_OFFSET[row] + value) | CMD_SET_DDRAM;
            end
            MODE_DISPLAY, MODE_CURSOR_SHOW, MODE_BLINK:
            begin
                enc.flags     = flags_upd;
                enc.data_byte = CMD_DISPLAY_CTL | {5'd0, flags_upd};
            end
            MODE_CLEAR:
            begin
                enc.data_byte = CMD_CLEAR;
            end
            MODE_HOME:
            begin
                enc.data_byte = CMD_HOME;
            end
            MODE_GLYPH_SLOT:
            begin
                enc.data_byte = CMD_SET_CGRAM + {value[4:0], 3'b000};
            end
            default:
            begin
                enc.send = 1'b0;
            end
        endcase
    end

endmodule

>>> rtl/char_lcd_nibble_writer.sv
// character lcd write front end for a 4-bit bus. each input transfer names one
// operation (raw command or data, translated cp1251 character, cursor placement,
// display/cursor/blink flag, clear, home, glyph slot select, glyph print) and
// turns into one byte that leaves as two output transfers: the high nibble with
// last low, then the low nibble with last high, both with the same reg_select.
// unused mode codes 11 to 15 produce no output transfer. an item is captured in
// the input register and then encoded into the byte register, from which its high
// nibble is the first on the bus. the four-bit output port moves one nibble a
// cycle while out_stall is low, so a byte-producing item holds the output for both
// of its nibbles; items that send nothing are dropped at the byte register. the
// byte register frees as its low nibble is taken, so a waiting item is loaded in
// the same cycle and a following byte goes out without a bubble
module char_lcd_nibble_writer
    import clnw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,

    input  logic       in_valid,
    output logic       in_stall,
    input  logic [3:0] mode,
    input  logic [7:0] value,
    input  logic [1:0] row,

    output logic       out_valid,
    input  logic       out_stall,
    output logic       reg_select,
    output logic [3:0] nibble,
    output logic       last
);

    // input register stage
    logic               item_valid_reg, item_valid_next;
    logic [3:0]         mode_reg;
    logic [7:0]         value_reg;
    logic [1:0]         row_reg;

    // byte register stage, phase high means low nibble on the bus
    logic               byte_valid_reg, byte_valid_next;
    logic               phase_reg, phase_next;
    logic               rs_reg;
    logic [7:0]         byte_reg;

    // display control flags kept between items
    logic [FLAGS_W-1:0] flags_reg, flags_next;

    enc_t               enc;
    logic               out_xfer;
    logic               byte_free;
    logic               advance;
    logic               in_xfer;

    clnw_encode u_encode (
        .mode  (mode_reg),
        .value (value_reg),
        .row   (row_reg),
        .flags (flags_reg),
        .enc   (enc)
    );

    // handshake
    assign out_xfer  = out_valid && !out_stall;
    assign byte_free = !byte_valid_reg || (out_xfer && phase_reg);
    assign advance   = item_valid_reg && byte_free;
    assign in_stall  = item_valid_reg && !advance;
    assign in_xfer   = in_valid && !in_stall;

    assign out_valid  = byte_valid_reg;
    assign reg_select = rs_reg;
    assign nibble     = phase_reg ? byte_reg[3:0] : byte_reg[7:4];
    assign last       = phase_reg;

    always_comb
    begin
        item_valid_next = in_xfer || (item_valid_reg && !advance);
        flags_next      = advance ? enc.flags : flags_reg;

        byte_valid_next = byte_valid_reg;
        phase_next      = phase_reg;
        if (advance)
        begin
            // dropped when the code sends nothing
            byte_valid_next = enc.send;
            phase_next      = 1'b0;
        end
        else if (out_xfer)
        begin
            if (phase_reg)
                byte_valid_next = 1'b0;
            else
                phase_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            byte_valid_reg <= 1'b0;
            phase_reg      <= 1'b0;
            flags_reg      <= FLAGS_RESET;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            byte_valid_reg <= byte_valid_next;
            phase_reg      <= phase_next;
            flags_reg      <= flags_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            mode_reg  <= mode;
            value_reg <= value;
            row_reg   <= row;
        end
        if (advance)
        begin
            rs_reg   <= enc.rs;
            byte_reg <= enc.data_byte;
        end
    end

    // a taken high nibble is always followed by its low nibble
    assert property (@(posedge clk) disable iff (!rst_n)
        out_xfer && !last |=> out_valid && last && $stable(reg_select))
        else $error("high nibble not followed by matching low nibble");

    // input only held off while the input register holds an item
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> item_valid_reg && !byte_free)
        else $error("input stalled with room to move");

    // flags only change when an item is encoded
    assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(flags_reg))
        else $error("display flags changed without an item");

    // a new byte always starts with its high nibble
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && enc.send |=> out_valid && !last)
        else $error("new byte did not start with high nibble");

endmodule

>>> sim/lcd_nibble_checker.sv
module lcd_nibble_checker
    import clnw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,

    input  logic       in_valid,
    input  logic       in_stall,
    input  logic [3:0] mode,
    input  logic [7:0] value,
    input  logic [1:0] row,

    input  logic       out_valid,
    input  logic       out_stall,
    input  logic       reg_select,
    input  logic [3:0] nibble,
    input  logic       last,

    output int         fail_count,
    output int         nibbles_owed,
    output int         nibbles_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    // one nibble on the lcd bus
    typedef struct packed {
        logic       rs;
        logic [3:0] nib;
        logic       last;
    } bus_nibble_t;

    // cp1251 letters 0xc0..0xff to controller code page
    localparam logic [7:0] CP1251_TO_LCD [64] = '{
        8'h41, 8'hA0, 8'h42, 8'hA1, 8'hE0, 8'h45, 8'hA3, 8'hA4,
        8'hA5, 8'hA6, 8'h4B, 8'hA7, 8'h4D, 8'h48, 8'h4F, 8'hA8,
        8'h50, 8'h43, 8'h54, 8'hA9, 8'hAA, 8'h58, 8'hE1, 8'hAB,
        8'hAC, 8'hE2, 8'hAD, 8'hAE, 8'h62, 8'hAF, 8'hB0, 8'hB1,
        8'h61, 8'hB2, 8'hB3, 8'hB4, 8'hE3, 8'h65, 8'hB6, 8'hB7,
        8'hB8, 8'hB9, 8'hBA, 8'hBB, 8'hBC, 8'hBD, 8'h6F, 8'hBE,
        8'h70, 8'h63, 8'hBF, 8'h79, 8'hE4, 8'h78, 8'hE5, 8'hC0,
        8'hC1, 8'hE6, 8'hC2, 8'hC3, 8'hC4, 8'hC5, 8'hC6, 8'hC7
    };

    localparam logic [7:0] LINE_START [4] = '{8'h00, 8'h40, 8'h14, 8'h54};

    bus_nibble_t        owed_nibbles [$];
    logic [FLAGS_W-1:0] shadow_flags;
    int                 errs;
    int                 seen;

    function automatic logic [7:0] lcd_char_code(input logic [7:0] c);
        if (c >= 8'hC0)
            return CP1251_TO_LCD[c[5:0]];
        if (c == 8'hA8)
            return 8'hA2;
        if (c == 8'hB8)
            return 8'hB5;
        return c;
    endfunction

    // a byte leaves high nibble first
    function automatic void owe_byte(input logic rs, input logic [7:0] b);
        owed_nibbles.push_back('{rs, b[7:4], 1'b0});
        owed_nibbles.push_back('{rs, b[3:0], 1'b1});
    endfunction

    function automatic void switch_flag(input logic [FLAGS_W-1:0] mask, input logic on);
        if (on)
            shadow_flags = shadow_flags | mask;
        else
            shadow_flags = shadow_flags & ~mask;
        owe_byte(1'b0, CMD_DISPLAY_CTL | {5'b0, shadow_flags});
    endfunction

    function automatic void predict_op(input logic [3:0] m, input logic [7:0] v,
                                       input logic [1:0] r);
        logic [7:0] addr;
        case (m)
            MODE_CMD:         owe_byte(1'b0, v);
            MODE_DATA:        owe_byte(1'b1, v);
            MODE_CHAR:        owe_byte(1'b1, lcd_char_code(v));
            MODE_CURSOR_POS:
            begin
                addr = LINE_START[r] + v;
                owe_byte(1'b0, addr | CMD_SET_DDRAM);
            end
            MODE_DISPLAY:     switch_flag(FLAG_DISPLAY, v != 8'd0);
            MODE_CURSOR_SHOW: switch_flag(FLAG_CURSOR, v != 8'd0);
            MODE_BLINK:       switch_flag(FLAG_BLINK, v != 8'd0);
            MODE_CLEAR:       owe_byte(1'b0, CMD_CLEAR);
            MODE_HOME:        owe_byte(1'b0, CMD_HOME);
            MODE_GLYPH_SLOT:  owe_byte(1'b0, CMD_SET_CGRAM + {v[4:0], 3'b000});
            MODE_GLYPH_PRINT: owe_byte(1'b1, v);
            default:          ; // unused codes send nothing
        endcase
    endfunction

    function automatic void flag_error(input string what);
        errs++;
        if (errs <= 10)
            $display("[%0t] error: %s", $realtime, what);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        bus_nibble_t got;
        bus_nibble_t want;
        if (!rst_n)
        begin
            owed_nibbles.delete();
            shadow_flags = FLAGS_RESET;
            errs = 0;
            seen = 0;
        end
        else
        begin
            // outputs first: a transfer accepted now cannot stem from this edge's input
            if (out_valid && !out_stall)
            begin
                got = '{reg_select, nibble, last};
                seen++;
                if (owed_nibbles.size() == 0)
                    flag_error($sformatf("unexpected transfer rs %0b nibble %h last %0b",
                                         got.rs, got.nib, got.last));
                else
                begin
                    want = owed_nibbles.pop_front();
                    if (got !== want)
                        flag_error($sformatf(
                            "rs %0b/%0b nibble %h/%h last %0b/%0b (expected/actual)",
                            want.rs, got.rs, want.nib, got.nib, want.last, got.last));
                end
            end
            if (in_valid && !in_stall)
                predict_op(mode, value, row);
        end
        fail_count   <= errs;
        nibbles_owed <= owed_nibbles.size();
        nibbles_seen <= seen;
    end

endmodule

>>> sim/tb_char_lcd_nibble_writer.sv
module tb_char_lcd_nibble_writer;
    timeunit 1ns;
    timeprecision 1ps;

    import clnw_pkg::*;

    localparam int CLK_PERIOD   = 12;
    localparam int RANDOM_OPS   = 700;
    localparam int CYCLE_LIMIT  = 250000;
    localparam int SETTLE_TICKS = 12;

    // receiver stall patterns
    typedef enum int {
        RX_OPEN,
        RX_LIGHT,
        RX_HEAVY,
        RX_COMB
    } rx_style_t;

    logic       clk;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    logic [3:0] mode      = 4'd0;
    logic [7:0] value     = 8'd0;
    logic [1:0] row       = 2'd0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic       reg_select;
    logic [3:0] nibble;
    logic       last;

    int chk_fail;
    int chk_owed;
    int chk_seen;

    int        ops_sent    = 0;
    int        burst_left  = 0;
    int        cycle_count = 0;
    rx_style_t rx_style    = RX_OPEN;
    int        rx_left     = 0;

    char_lcd_nibble_writer dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .mode       (mode),
        .value      (value),
        .row        (row),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .reg_select (reg_select),
        .nibble     (nibble),
        .last       (last)
    );

    // watches both channels, predicts every nibble and compares
    lcd_nibble_checker nibble_chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .mode         (mode),
        .value        (value),
        .row          (row),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .reg_select   (reg_select),
        .nibble       (nibble),
        .last         (last),
        .fail_count   (chk_fail),
        .nibbles_owed (chk_owed),
        .nibbles_seen (chk_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // watchdog, far beyond the slowest legal run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("watchdog expired after %0d cycles, %0d nibbles still owed",
                     cycle_count, chk_owed);
            $display("simulation failed");
            $finish;
        end
    end

    // receiver: stall style is redrawn whenever its run counter expires, open stretches included
    always @(posedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_style <= rx_style_t'($urandom_range(0, 3));
            rx_left  <= $urandom_range(30, 160);
        end
        else
            rx_left <= rx_left - 1;
        case (rx_style)
            RX_OPEN:  out_stall <= 1'b0;
            RX_LIGHT: out_stall <= ($urandom_range(0, 99) < 25);
            RX_HEAVY: out_stall <= ($urandom_range(0, 99) < 75);
            RX_COMB:  out_stall <= ((cycle_count % 5) < 2);
            default:  out_stall <= 1'b0;
        endcase
    end

    // one input transfer; valid stays high inside a burst, a gap follows each burst
    task automatic issue_op(input logic [3:0] m, input logic [7:0] v, input logic [1:0] r);
        in_valid <= 1'b1;
        mode     <= m;
        value    <= v;
        row      <= r;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        ops_sent++;
        burst_left--;
        if (burst_left <= 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = $urandom_range(1, 40);
        end
    endtask

    // hold the sender off until every owed nibble has left the block
    task automatic drain_output();
        in_valid <= 1'b0;
        @(posedge clk);
        while (chk_owed != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int         ops_done;
        int         kind;
        int         len;
        bit         paused;
        logic [3:0] m;
        logic [7:0] v;
        logic [7:0] glyph;

        ops_done   = 0;
        paused     = 1'b0;
        burst_left = $urandom_range(1, 40);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed corners: byte extremes, every operation, cyrillic edges, wraps
        issue_op(MODE_CMD,         8'h00, 2'd3);
        issue_op(MODE_CMD,         8'hFF, 2'd0);
        issue_op(MODE_DATA,        8'h00, 2'd0);
        issue_op(MODE_DATA,        8'hFF, 2'd3);
        issue_op(MODE_CHAR,        8'hC0, 2'd0);    // first capital letter
        issue_op(MODE_CHAR,        8'hFF, 2'd0);    // last small letter
        issue_op(MODE_CHAR,        8'hA8, 2'd0);    // capital yo
        issue_op(MODE_CHAR,        8'hB8, 2'd0);    // small yo
        issue_op(MODE_CHAR,        8'h00, 2'd0);    // zero passes through
        issue_op(MODE_CHAR,        8'hBF, 2'd0);    // just below the letter block
        issue_op(MODE_CURSOR_POS,  8'h00, 2'd0);
        issue_op(MODE_CURSOR_POS,  8'h0F, 2'd1);
        issue_op(MODE_CURSOR_POS,  8'h13, 2'd2);
        issue_op(MODE_CURSOR_POS,  8'hFF, 2'd3);    // address wraps at 8 bits
        issue_op(MODE_DISPLAY,     8'h00, 2'd2);
        issue_op(MODE_CURSOR_SHOW, 8'hFF, 2'd0);
        issue_op(MODE_BLINK,       8'h01, 2'd0);
        issue_op(MODE_DISPLAY,     8'h80, 2'd0);
        issue_op(MODE_BLINK,       8'h00, 2'd1);
        issue_op(MODE_CLEAR,       8'hAA, 2'd3);
        issue_op(MODE_HOME,        8'h55, 2'd0);
        issue_op(MODE_GLYPH_SLOT,  8'h00, 2'd0);
        issue_op(MODE_GLYPH_SLOT,  8'hFF, 2'd0);    // slot command wraps
        issue_op(MODE_GLYPH_PRINT, 8'h07, 2'd0);
        issue_op(4'd11,            8'h12, 2'd1);    // unused code, no output
        issue_op(4'd15,            8'hFF, 2'd3);

        // random part: single ops, glyph loads and positioned strings
        while (ops_done < RANDOM_OPS)
        begin
            // once midway, let the output run dry with the sender held off
            if (!paused && ops_done >= RANDOM_OPS / 2)
            begin
                drain_output();
                repeat ($urandom_range(5, 30)) @(posedge clk);
                paused = 1'b1;
            end
            kind = $urandom_range(0, 99);
            if (kind < 15)
            begin
                // glyph load: slot select, eight pixel rows, then print it
                glyph = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
                issue_op(MODE_GLYPH_SLOT, glyph, 2'($urandom));
                repeat (8) issue_op(MODE_DATA, 8'($urandom_range(0, 31)), 2'($urandom));
                issue_op(MODE_GLYPH_PRINT, glyph & 8'h07, 2'($urandom));
                ops_done += 10;
            end
            else if (kind < 30)
            begin
                // cursor placement, then a mostly cyrillic string
                issue_op(MODE_CURSOR_POS, 8'($urandom_range(0, 19)), 2'($urandom));
                len = $urandom_range(3, 16);
                repeat (len)
                begin
                    case ($urandom_range(0, 5))
                        0:       v = 8'hA8;
                        1:       v = 8'hB8;
                        2:       v = 8'($urandom_range(8'h20, 8'h7E));
                        default: v = 8'($urandom_range(8'hC0, 8'hFF));
                    endcase
                    issue_op(MODE_CHAR, v, 2'($urandom));
                end
                ops_done += len + 1;
            end
            else
            begin
                // any single op, a few unused codes as noise
                if ($urandom_range(0, 9) == 0)
                    m = 4'($urandom_range(11, 15));
                else
                    m = 4'($urandom_range(0, 10));
                case ($urandom_range(0, 3))
                    0:       v = 8'h00;
                    1:       v = 8'hFF;
                    default: v = 8'($urandom);
                endcase
                if (m == MODE_CHAR && $urandom_range(0, 1) == 1)
                    v = 8'($urandom_range(8'hA8, 8'hFF));
                issue_op(m, v, 2'($urandom));
                if (m <= MODE_GLYPH_PRINT)
                    ops_done++;
            end
        end

        // wait for the tail, then let the clock run on to catch stray transfers
        drain_output();
        repeat (SETTLE_TICKS) @(posedge clk);

        $display("covered %0d input transfers: all mode codes, cp1251 edges, wraps,",
                 ops_sent);
        $display("glyph loads and strings, %0d nibble transfers under four stall patterns",
                 chk_seen);
        if (chk_fail == 0 && chk_owed == 0)
            $display("simulation ok");
        else
        begin
            $display("%0d errors, %0d nibbles never seen", chk_fail, chk_owed);
            $display("simulation failed");
        end
        $finish;
    end

endmodule

>>> char_lcd_nibble_writer.f
rtl/clnw_pkg.sv
rtl/clnw_encode.sv
rtl/char_lcd_nibble_writer.sv
sim/lcd_nibble_checker.sv
sim/tb_char_lcd_nibble_writer.sv
